// ===== hw/rtl/rgbled_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbled_pkg
// Shared constants, types and the division step function for the RGB to
// LED global brightness converter.
// ----------------------------------------------------------------------------
package rgbled_pkg;

  localparam int unsigned InW       = 32;
  localparam int unsigned LevelW    = 13;
  localparam int unsigned PreW      = 5;
  localparam int unsigned ColorW    = 8;
  localparam int unsigned QuoW      = 9;
  localparam int unsigned InDataW   = 3 * InW;
  localparam int unsigned OutDataW  = 32;

  // Level = intensity / 541200, done as a reciprocal multiply and one fix-up.
  localparam logic [31:0] LevelDivisor = 32'd541200;
  localparam logic [25:0] RecipMult    = 26'd65011774;
  localparam int unsigned RecipShift   = 45;
  localparam int unsigned ProdW        = InW + 26;

  localparam logic [PreW-1:0]   PreMax   = 5'd31;
  localparam logic [ColorW-1:0] ColorMax = 8'd255;

  typedef logic [LevelW-1:0] level_t;

  typedef struct packed {
    logic [LevelW-1:0] rem;
    logic [QuoW-1:0]   quo;
  } div_t;

  // Restoring division steps for quotient bits hi down to lo.
  function automatic div_t div_steps(div_t acc, logic [PreW-1:0] divisor, int hi, int lo);
    div_t              res;
    logic [LevelW-1:0] d;
    res = acc;
    for (int i = QuoW - 1; i >= 0; i--) begin
      d = LevelW'(divisor) << i;
      if (i <= hi && i >= lo && res.rem >= d) begin
        res.rem    = res.rem - d;
        res.quo[i] = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/rgbled_level.sv =====
// ----------------------------------------------------------------------------
// rgbled_level
// Three-stage divider of one 32-bit intensity by the level divisor.
// ----------------------------------------------------------------------------
module rgbled_level (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [rgbled_pkg::InW-1:0] data_i,
  output rgbled_pkg::level_t       level_o
);
  import rgbled_pkg::*;

  logic [ProdW-1:0]  prod_q;
  logic [InW-1:0]    x1_q, x2_q;
  logic [InW-1:0]    back_q;
  level_t            qe_q, level_q;
  level_t            qe;
  logic [InW-1:0]    rem;

  // The estimate is never above the true quotient and at most one below it.
  assign qe  = prod_q[RecipShift +: LevelW];
  assign rem = x2_q - back_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= ProdW'(data_i) * ProdW'(RecipMult);
      x1_q    <= data_i;
      back_q  <= InW'(InW'(qe) * LevelDivisor);
      qe_q    <= qe;
      x2_q    <= x1_q;
      level_q <= (rem >= LevelDivisor) ? level_t'(qe_q + 1'b1) : qe_q;
    end
  end

  assign level_o = level_q;

endmodule

// ===== hw/rtl/rgb_to_led_global_brightness_unit.sv =====
// ----------------------------------------------------------------------------
// rgb_to_led_global_brightness_unit
// Converts 32-bit RGB intensities into an LED pixel word: a 5-bit global
// brightness prescaler and three 8-bit colors.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle; the six-stage pipeline holds when the
// output is stalled.
// Reset clears only the stage valid bits; the datapath registers are not reset.
module rgb_to_led_global_brightness_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] red_in, [63:32] green_in, [95:64] blue_in
  input  logic [rgbled_pkg::InDataW-1:0]  s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] brightness, [12:5] red_out, [20:13] green_out, [28:21] blue_out,
  // [31:29] zero
  output logic [rgbled_pkg::OutDataW-1:0] m_axis_tdata
);
  import rgbled_pkg::*;

  localparam int unsigned Stages = 6;

  logic [Stages-1:0] valid_d, valid_q;
  logic              en;
  level_t            level [3];
  level_t            max_lvl;
  logic [PreW-1:0]   pre;

  level_t            lvl4_q [3];
  logic [PreW-1:0]   pre4_q, pre5_q, pre6_q;
  div_t              div5_q [3];
  logic [ColorW-1:0] color6_q [3];
  div_t              div5 [3];
  div_t              div6 [3];

  assign en            = !valid_q[Stages-1] || m_axis_tready;
  assign s_axis_tready = en;

  assign valid_d = en ? {valid_q[Stages-2:0], s_axis_tvalid} : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_level
    rgbled_level u_level (
      .clk_i  (clk_i),
      .en_i   (en),
      .data_i (s_axis_tdata[c*InW +: InW]),
      .level_o(level[c])
    );
  end

  // Every level fits under 256 * p exactly when p exceeds max / 256, and that
  // bound is never below the start value taken from the minimum.
  always_comb begin
    max_lvl = level[0];
    if (level[1] > max_lvl) max_lvl = level[1];
    if (level[2] > max_lvl) max_lvl = level[2];
    if (max_lvl[LevelW-1 -: PreW] == PreMax) begin
      pre = PreMax;
    end else begin
      pre = max_lvl[LevelW-1 -: PreW] + 1'b1;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      div5[c] = div_steps('{rem: lvl4_q[c], quo: '0}, pre4_q, 8, 4);
      div6[c] = div_steps(div5_q[c], pre5_q, 3, 0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pre4_q <= pre;
      pre5_q <= pre4_q;
      pre6_q <= pre5_q;
      for (int c = 0; c < 3; c++) begin
        lvl4_q[c] <= level[c];
        div5_q[c] <= div5[c];
        // Only a level above 7935 at the prescaler cap gives a quotient of 256.
        color6_q[c] <= div6[c].quo[QuoW-1] ? ColorMax : div6[c].quo[ColorW-1:0];
      end
    end
  end

  assign m_axis_tvalid = valid_q[Stages-1];
  assign m_axis_tdata  = {3'b000, color6_q[2], color6_q[1], color6_q[0], pre6_q};

endmodule

// ===== hw/rtl/rgbled_checker.sv =====
// ----------------------------------------------------------------------------
// rgbled_checker
// Port-level checks for the RGB to LED global brightness converter.
// ----------------------------------------------------------------------------
module rgbled_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [rgbled_pkg::OutDataW-1:0] m_axis_tdata
);

  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped during a stall");

  a_out_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output data changed during a stall");

  a_bright_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[4:0] != 5'd0)
    else $error("brightness of zero on output");

  // A prescaler above one is only chosen when some color stays at 128 or more.
  a_bright_needed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[4:0] > 5'd1 |->
      m_axis_tdata[12] || m_axis_tdata[20] || m_axis_tdata[28])
    else $error("prescaler larger than needed");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input not ready with an empty output stage");

endmodule

bind rgb_to_led_global_brightness_unit rgbled_checker u_rgbled_checker (.*);

// ===== tb/tb_rgb_to_led_global_brightness_unit.sv =====
// ----------------------------------------------------------------------------
// tb_rgb_to_led_global_brightness_unit
// Self-checking bench for the RGB to LED pixel converter. A short table of
// corner pixels is followed by random pixels, each predicted in the bench and
// compared field by field with the output stream. Both stream sides idle in
// random bursts, and the output side once stalls long enough to back up the
// pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rgb_to_led_global_brightness_unit;
  import rgbled_pkg::*;

  localparam int unsigned PreStep   = 256;
  localparam int unsigned RandItems = 1750;
  localparam int unsigned HoldAt    = 300;
  localparam int unsigned HoldLen   = 300;
  localparam int unsigned CalmItems = 150;
  localparam int unsigned TopLevel  = 7936;

  // Output word layout, lowest bits last.
  typedef struct packed {
    logic [2:0]        pad;
    logic [ColorW-1:0] blue;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] red;
    logic [PreW-1:0]   bright;
  } led_word_t;

  typedef struct packed {
    logic [InW-1:0] red;
    logic [InW-1:0] green;
    logic [InW-1:0] blue;
    logic           known;
    led_word_t      want;
  } pixel_row_t;

  typedef enum int unsigned {
    MixFull,
    MixDim,
    MixEven,
    MixAny,
    MixHot
  } pixel_mix_e;

  localparam led_word_t Unset = '0;
  localparam int unsigned DirN = 17;

  // Rows with known set carry a result that follows directly from the levels:
  // all dark, full scale (prescaler capped, colors saturated), a single
  // saturated channel, level 255 passing through, and tiny levels.
  localparam pixel_row_t DirTab [DirN] = '{
    '{32'd0, 32'd0, 32'd0, 1'b1, '{3'd0, 8'd0, 8'd0, 8'd0, 5'd1}},
    '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, '{3'd0, 8'd255, 8'd255, 8'd255, 5'd31}},
    '{32'hFFFFFFFF, 32'd0, 32'd0, 1'b1, '{3'd0, 8'd0, 8'd0, 8'd255, 5'd31}},
    '{32'd0, 32'hFFFFFFFF, 32'd0, 1'b1, '{3'd0, 8'd0, 8'd255, 8'd0, 5'd31}},
    '{32'd0, 32'd0, 32'hFFFFFFFF, 1'b1, '{3'd0, 8'd255, 8'd0, 8'd0, 5'd31}},
    '{32'd138006000, 32'd138006000, 32'd138006000, 1'b1,
      '{3'd0, 8'd255, 8'd255, 8'd255, 5'd1}},
    '{32'd541199, 32'd541200, 32'd1082400, 1'b1, '{3'd0, 8'd2, 8'd1, 8'd0, 5'd1}},
    '{32'd138547200, 32'd138547200, 32'd138547200, 1'b0, Unset},
    '{32'd4278186000, 32'd4278186000, 32'd4278186000, 1'b0, Unset},
    '{32'd4278727200, 32'd0, 32'd4278186000, 1'b0, Unset},
    '{32'd4294963200, 32'd4294963200, 32'd4294963200, 1'b0, Unset},
    '{32'hAAAAAAAA, 32'h55555555, 32'hFFFF0000, 1'b0, Unset},
    '{32'h55555555, 32'h0000FFFF, 32'hAAAAAAAA, 1'b0, Unset},
    '{32'h80000000, 32'h7FFFFFFF, 32'h00000001, 1'b0, Unset},
    '{32'd138006000, 32'd138547200, 32'd0, 1'b0, Unset},
    '{32'd1082400000, 32'd1082400000, 32'd1082400000, 1'b0, Unset},
    '{32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 1'b0, Unset}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  // Expectation that travels with the pixel on the input bus.
  logic      cur_known = 1'b0;
  led_word_t cur_want = '0;

  led_word_t pending_q[$];
  int unsigned errs = 0;
  bit quiet = 1'b0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  rgb_to_led_global_brightness_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Prescaler starts at the dimmest level over 256 and rises until every
  // channel fits in 8 bits, capped at the top code; colors then saturate.
  function automatic led_word_t scale_pixel(logic [InW-1:0] r, logic [InW-1:0] g,
                                            logic [InW-1:0] b);
    int unsigned lvl [3];
    int unsigned pre;
    int unsigned q;
    led_word_t   w;
    lvl[0] = r / LevelDivisor;
    lvl[1] = g / LevelDivisor;
    lvl[2] = b / LevelDivisor;
    pre = lvl[0] / PreStep;
    if (lvl[1] / PreStep < pre) pre = lvl[1] / PreStep;
    if (lvl[2] / PreStep < pre) pre = lvl[2] / PreStep;
    if (pre == 0) pre = 1;
    if (pre > PreMax) pre = PreMax;
    while (pre < PreMax && (lvl[0] / pre > ColorMax || lvl[1] / pre > ColorMax ||
                            lvl[2] / pre > ColorMax))
      pre++;
    w = '0;
    w.bright = PreW'(pre);
    for (int i = 0; i < 3; i++) begin
      q = lvl[i] / pre;
      if (q > ColorMax) q = ColorMax;
      case (i)
        0: w.red = ColorW'(q);
        1: w.green = ColorW'(q);
        default: w.blue = ColorW'(q);
      endcase
    end
    return w;
  endfunction

  // Intensity that lands on a given level, with a random remainder.
  function automatic logic [InW-1:0] intensity_at(int unsigned lvl);
    longint unsigned v;
    int unsigned     rem;
    if (lvl >= TopLevel) begin
      lvl = TopLevel;
      rem = $urandom_range(0, 4095);
    end else begin
      rem = $urandom_range(0, LevelDivisor - 1);
    end
    v = longint'(lvl) * LevelDivisor + rem;
    return v[InW-1:0];
  endfunction

  task automatic push_pixel(input logic [InW-1:0] r, input logic [InW-1:0] g,
                            input logic [InW-1:0] b, input logic known,
                            input led_word_t want);
    int unsigned gap;
    if (!calm && !quiet && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      gap = $urandom_range(1, 11);
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, g, r};
    cur_known     <= known;
    cur_want      <= want;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  initial begin : pixel_source
    logic [InW-1:0] ch [3];
    pixel_mix_e     mix;
    int unsigned    base;
    int unsigned    lo;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int k = 0; k < DirN; k++)
      push_pixel(DirTab[k].red, DirTab[k].green, DirTab[k].blue, DirTab[k].known,
                 DirTab[k].want);
    for (int k = 0; k < RandItems; k++) begin
      if (k % 64 == 0) quiet = ($urandom_range(0, 2) == 0);
      if (k == HoldAt) hold_req = 1'b1;
      if (k == RandItems - CalmItems) calm = 1'b1;
      mix  = pixel_mix_e'($urandom_range(0, 4));
      base = $urandom_range(0, TopLevel);
      for (int i = 0; i < 3; i++) begin
        case (mix)
          MixFull: ch[i] = $urandom;
          MixDim:  ch[i] = intensity_at($urandom_range(0, 300));
          MixEven: begin
            lo = (base > 40) ? base - 40 : 0;
            ch[i] = intensity_at($urandom_range(lo, base + 40));
          end
          MixHot:  ch[i] = intensity_at($urandom_range(7850, TopLevel));
          default: ch[i] = ($urandom_range(0, 5) == 0) ? '0
                                                        : intensity_at($urandom_range(0, TopLevel));
        endcase
      end
      push_pixel(ch[0], ch[1], ch[2], 1'b0, Unset);
    end
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errs == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin : pixel_sink
    int unsigned stall;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        // Long hold-off so the pipeline fills and input backpressure shows.
        m_axis_tready <= 1'b0;
        for (int n = 0; n < HoldLen; n++) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!calm && !quiet && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        stall = $urandom_range(1, 11);
        // The loop head adds the last cycle of the burst.
        repeat (stall - 1) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    led_word_t got;
    led_word_t exp_w;
    if (s_axis_tvalid && s_axis_tready) begin
      if (cur_known) pending_q.push_back(cur_want);
      else pending_q.push_back(scale_pixel(s_axis_tdata[31:0], s_axis_tdata[63:32],
                                           s_axis_tdata[95:64]));
    end
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected pixel word %h", $time, got);
        errs++;
      end else begin
        exp_w = pending_q.pop_front();
        if (got.bright !== exp_w.bright) begin
          $display("%0t: brightness expected %0d got %0d", $time, exp_w.bright, got.bright);
          errs++;
        end
        if (got.red !== exp_w.red) begin
          $display("%0t: red expected %0d got %0d", $time, exp_w.red, got.red);
          errs++;
        end
        if (got.green !== exp_w.green) begin
          $display("%0t: green expected %0d got %0d", $time, exp_w.green, got.green);
          errs++;
        end
        if (got.blue !== exp_w.blue) begin
          $display("%0t: blue expected %0d got %0d", $time, exp_w.blue, got.blue);
          errs++;
        end
        if (got.pad !== 3'd0) begin
          $display("%0t: pad bits expected 0 got %b", $time, got.pad);
          errs++;
        end
      end
    end
  end

  initial begin : watchdog
    #1000000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/rgbled_pkg.sv
hw/rtl/rgbled_level.sv
hw/rtl/rgb_to_led_global_brightness_unit.sv
hw/rtl/rgbled_checker.sv
tb/tb_rgb_to_led_global_brightness_unit.sv
